// ===== rtl/u16550_pkg.sv =====
`default_nettype none

package u16550_pkg;

    // Default transmit ring depth
    localparam int FIFO_DEPTH_DEFAULT = 16;

    // Item widths
    localparam int FUNC_W   = 2;
    localparam int OFFSET_W = 8;
    localparam int DATA_W   = 8;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [DATA_W-1:0]   byte_t;
    typedef logic [2:0]          reg_idx_t;

    // Item function codes
    localparam func_t FUNC_READ  = 2'd0;
    localparam func_t FUNC_WRITE = 2'd1;
    localparam func_t FUNC_DRAIN = 2'd2;

    // Register indexes within the eight-register window
    localparam reg_idx_t REG_RBR_THR = 3'd0;
    localparam reg_idx_t REG_IER     = 3'd1;
    localparam reg_idx_t REG_IIR_FCR = 3'd2;
    localparam reg_idx_t REG_LCR     = 3'd3;
    localparam reg_idx_t REG_MCR     = 3'd4;
    localparam reg_idx_t REG_LSR     = 3'd5;
    localparam reg_idx_t REG_MSR     = 3'd6;
    localparam reg_idx_t REG_SCR     = 3'd7;

    // Register bit fields
    localparam int    DLAB_BIT       = 7;
    localparam int    FCR_ENABLE_BIT = 0;
    localparam int    FCR_CLEAR_BIT  = 2;
    localparam byte_t IIR_FIFO_BITS  = 8'hC0;
    localparam byte_t IIR_NO_PENDING = 8'h01;
    localparam byte_t LSR_EMPTY_BITS = 8'h60;

endpackage : u16550_pkg

`default_nettype wire

// ===== rtl/uart_16550_register_model.sv =====
`default_nettype none

// 16550-style UART register file, transmit side only. Each input beat is a bus
// read, a bus write, or a drain of one byte from the transmit ring, and each
// gives exactly one result beat. The register index is offset[4:2]; LCR bit 7
// (DLAB) banks indices 0 and 1 over DLL/DLM. A THR write pushes into a ring of
// FIFO_DEPTH bytes (capacity 1 while the FIFO is off), dropping the oldest byte
// when full. It accepts one beat per cycle while in_stall is low and registers
// each result in stage 1, beside the synchronous ring memory read, then in the
// output register. The ring memory needs no clearing pass after reset.
module uart_16550_register_model #(
    parameter int FIFO_DEPTH = u16550_pkg::FIFO_DEPTH_DEFAULT
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire u16550_pkg::func_t   func,
    input  wire u16550_pkg::offset_t offset,
    input  wire u16550_pkg::byte_t   write_data,
    output logic                   out_valid,
    input  wire                    out_stall,
    output u16550_pkg::byte_t      read_data,
    output logic                   status,
    output logic                   tx_request,
    output logic                   tx_valid,
    output u16550_pkg::byte_t      tx_byte
);

    import u16550_pkg::*;

    localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FIFO_DEPTH - 1);

    // Architectural registers
    byte_t            divisor_low_reg,   divisor_low_next;
    byte_t            divisor_high_reg,  divisor_high_next;
    byte_t            irq_enable_reg,    irq_enable_next;
    byte_t            line_control_reg,  line_control_next;
    byte_t            modem_control_reg, modem_control_next;
    byte_t            scratch_reg,       scratch_next;
    logic             fifo_enabled_reg,  fifo_enabled_next;
    logic [IDX_W-1:0] ring_head_reg,     ring_head_next;
    logic [IDX_W-1:0] ring_tail_reg,     ring_tail_next;
    logic [CNT_W-1:0] ring_count_reg,    ring_count_next;

    // Transmit ring memory
    byte_t ring_mem [FIFO_DEPTH];
    byte_t ring_rd_reg;

    // Pipeline stage between accept and output
    logic  s1_valid_reg;
    byte_t s1_read_data_reg, s1_read_data_next;
    logic  s1_status_reg,    s1_status_next;
    logic  s1_request_reg,   s1_request_next;
    logic  s1_pop_reg,       s1_pop_next;

    // Output register
    logic  out_valid_reg;
    byte_t out_read_data_reg;
    logic  out_status_reg;
    logic  out_request_reg;
    logic  out_pop_reg;
    byte_t out_byte_reg;

    logic     accept;
    logic     s1_advance;
    logic     out_free;
    logic     ring_we;
    logic     ring_re;
    logic     dlab;
    logic     high_index;
    reg_idx_t reg_idx;
    logic [CNT_W-1:0] count_dec;
    logic [CNT_W-1:0] capacity;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == LAST_IDX)
            r = '0;
        else
            r = idx + IDX_W'(1);
        return r;
    endfunction

    // Handshake: stage 1 moves on when the output register is free or drains
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign accept     = in_valid && !in_stall;

    assign dlab       = line_control_reg[DLAB_BIT];
    assign reg_idx    = offset[4:2];
    assign high_index = (offset[7:5] != 3'd0);
    assign capacity   = fifo_enabled_reg ? DEPTH_CNT : CNT_W'(1);

    // Decode the beat and compute next state
    always_comb
    begin
        divisor_low_next   = divisor_low_reg;
        divisor_high_next  = divisor_high_reg;
        irq_enable_next    = irq_enable_reg;
        line_control_next  = line_control_reg;
        modem_control_next = modem_control_reg;
        scratch_next       = scratch_reg;
        fifo_enabled_next  = fifo_enabled_reg;
        ring_head_next     = ring_head_reg;
        ring_tail_next     = ring_tail_reg;
        ring_count_next    = ring_count_reg;
        s1_read_data_next  = '0;
        s1_status_next     = 1'b0;
        s1_request_next    = 1'b0;
        s1_pop_next        = 1'b0;
        ring_we            = 1'b0;
        ring_re            = 1'b0;
        count_dec          = ring_count_reg;

        if (accept)
        begin
            unique case (func)
                FUNC_READ:
                begin
                    if (high_index)
                        s1_status_next = 1'b1;
                    else
                    begin
                        unique case (reg_idx)
                            REG_RBR_THR: s1_read_data_next = dlab ? divisor_low_reg : '0;
                            REG_IER:     s1_read_data_next = dlab ? divisor_high_reg
                                                                  : irq_enable_reg;
                            REG_IIR_FCR: s1_read_data_next = IIR_NO_PENDING |
                                             (fifo_enabled_reg ? IIR_FIFO_BITS : '0);
                            REG_LCR:     s1_read_data_next = line_control_reg;
                            REG_MCR:     s1_read_data_next = modem_control_reg;
                            REG_LSR:     s1_read_data_next = (ring_count_reg == '0)
                                                             ? LSR_EMPTY_BITS : '0;
                            REG_MSR:     s1_read_data_next = '0;
                            REG_SCR:     s1_read_data_next = scratch_reg;
                            default:     s1_read_data_next = '0;
                        endcase
                    end
                end
                FUNC_WRITE:
                begin
                    if (high_index)
                        s1_status_next = 1'b1;
                    else
                    begin
                        unique case (reg_idx)
                            REG_RBR_THR:
                            begin
                                if (dlab)
                                    divisor_low_next = write_data;
                                else
                                begin
                                    // Push, dropping the oldest byte when at capacity
                                    ring_head_next = ring_head_reg;
                                    if (ring_count_reg >= capacity)
                                    begin
                                        ring_head_next = ring_next(ring_head_reg);
                                        count_dec      = ring_count_reg - CNT_W'(1);
                                    end
                                    ring_we         = 1'b1;
                                    ring_tail_next  = ring_next(ring_tail_reg);
                                    ring_count_next = (count_dec < DEPTH_CNT)
                                                      ? count_dec + CNT_W'(1) : count_dec;
                                    s1_request_next = 1'b1;
                                end
                            end
                            REG_IER:
                            begin
                                if (dlab)
                                    divisor_high_next = write_data;
                                else
                                    irq_enable_next = write_data;
                            end
                            REG_IIR_FCR:
                            begin
                                if (write_data[FCR_CLEAR_BIT])
                                begin
                                    ring_head_next  = '0;
                                    ring_tail_next  = '0;
                                    ring_count_next = '0;
                                end
                                fifo_enabled_next = write_data[FCR_ENABLE_BIT];
                            end
                            REG_LCR: line_control_next  = write_data;
                            REG_MCR: modem_control_next = write_data;
                            REG_SCR: scratch_next       = write_data;
                            REG_LSR, REG_MSR: s1_status_next = 1'b1;
                            default: s1_status_next = 1'b1;
                        endcase
                    end
                end
                FUNC_DRAIN:
                begin
                    // Pop the oldest byte; the memory returns it next cycle
                    if (ring_count_reg != '0)
                    begin
                        ring_re         = 1'b1;
                        s1_pop_next     = 1'b1;
                        ring_head_next  = ring_next(ring_head_reg);
                        ring_count_next = ring_count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    s1_status_next = 1'b0;
                end
            endcase
        end
    end

    // Write and read the ring memory
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[ring_tail_reg] <= write_data;
        if (ring_re)
            ring_rd_reg <= ring_mem[ring_head_reg];
    end

    // Update architectural state and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_low_reg   <= '0;
            divisor_high_reg  <= '0;
            irq_enable_reg    <= '0;
            line_control_reg  <= '0;
            modem_control_reg <= '0;
            scratch_reg       <= '0;
            fifo_enabled_reg  <= 1'b0;
            ring_head_reg     <= '0;
            ring_tail_reg     <= '0;
            ring_count_reg    <= '0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            divisor_low_reg   <= divisor_low_next;
            divisor_high_reg  <= divisor_high_next;
            irq_enable_reg    <= irq_enable_next;
            line_control_reg  <= line_control_next;
            modem_control_reg <= modem_control_next;
            scratch_reg       <= scratch_next;
            fifo_enabled_reg  <= fifo_enabled_next;
            ring_head_reg     <= ring_head_next;
            ring_tail_reg     <= ring_tail_next;
            ring_count_reg    <= ring_count_next;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;
            if (s1_advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold stage 1 payload until it moves to the output
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_read_data_reg <= s1_read_data_next;
            s1_status_reg    <= s1_status_next;
            s1_request_reg   <= s1_request_next;
            s1_pop_reg       <= s1_pop_next;
        end
        if (s1_advance)
        begin
            out_read_data_reg <= s1_read_data_reg;
            out_status_reg    <= s1_status_reg;
            out_request_reg   <= s1_request_reg;
            out_pop_reg       <= s1_pop_reg;
            out_byte_reg      <= s1_pop_reg ? ring_rd_reg : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = out_read_data_reg;
    assign status     = out_status_reg;
    assign tx_request = out_request_reg;
    assign tx_valid   = out_pop_reg;
    assign tx_byte    = out_byte_reg;

endmodule : uart_16550_register_model

`default_nettype wire

// ===== dv/uart_16550_register_model_test.sv =====
module uart_16550_register_model_test;
    timeunit 1ns;
    timeprecision 1ps;

    import u16550_pkg::*;

    localparam int    RING_DEPTH   = FIFO_DEPTH_DEFAULT;
    localparam int    HOLD_CYCLES  = 64;
    localparam int    PRINT_LIMIT  = 40;
    localparam func_t FUNC_UNUSED  = 2'd3;

    typedef struct packed {
        byte_t read_data;
        logic  status;
        logic  tx_request;
        logic  tx_valid;
        byte_t tx_byte;
    } reply_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    func_t   func;
    offset_t offset;
    byte_t   write_data;
    logic    out_valid;
    logic    out_stall;
    byte_t   read_data;
    logic    status;
    logic    tx_request;
    logic    tx_valid;
    byte_t   tx_byte;

    // Shadow copy of the register file and transmit ring
    byte_t shadow_dll = '0;
    byte_t shadow_dlm = '0;
    byte_t shadow_ier = '0;
    byte_t shadow_lcr = '0;
    byte_t shadow_mcr = '0;
    byte_t shadow_scr = '0;
    logic  shadow_fifo_on = 1'b0;
    byte_t tx_shadow [RING_DEPTH];
    int    tx_head = 0;
    int    tx_tail = 0;
    int    tx_count = 0;

    reply_t reply_q [$];
    int     error_count = 0;
    logic   idle_enabled = 1'b1;
    logic   hold_request = 1'b0;
    int     hold_count;

    uart_16550_register_model dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .offset     (offset),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .status     (status),
        .tx_request (tx_request),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Work out the reply to one access and advance the shadow state
    function automatic reply_t predict_reply(input func_t f, input offset_t o, input byte_t d);
        reply_t   r;
        reg_idx_t idx;
        logic     in_window;
        logic     dlab;
        int       cap;
        r = '0;
        idx = o[4:2];
        in_window = (o[7:5] == 3'b000);
        dlab = shadow_lcr[DLAB_BIT];
        case (f)
            FUNC_READ:
            begin
                if (!in_window)
                    r.status = 1'b1;
                else
                begin
                    case (idx)
                        REG_RBR_THR: r.read_data = dlab ? shadow_dll : '0;
                        REG_IER:     r.read_data = dlab ? shadow_dlm : shadow_ier;
                        REG_IIR_FCR: r.read_data = IIR_NO_PENDING |
                                                   (shadow_fifo_on ? IIR_FIFO_BITS : '0);
                        REG_LCR:     r.read_data = shadow_lcr;
                        REG_MCR:     r.read_data = shadow_mcr;
                        REG_LSR:     r.read_data = (tx_count == 0) ? LSR_EMPTY_BITS : '0;
                        REG_MSR:     r.read_data = '0;
                        REG_SCR:     r.read_data = shadow_scr;
                    endcase
                end
            end
            FUNC_WRITE:
            begin
                if (!in_window)
                    r.status = 1'b1;
                else
                begin
                    case (idx)
                        REG_RBR_THR:
                        begin
                            if (dlab)
                                shadow_dll = d;
                            else
                            begin
                                // drop the oldest byte when at capacity
                                cap = shadow_fifo_on ? RING_DEPTH : 1;
                                if (tx_count >= cap)
                                begin
                                    tx_head = (tx_head + 1) % RING_DEPTH;
                                    tx_count--;
                                end
                                tx_shadow[tx_tail] = d;
                                tx_tail = (tx_tail + 1) % RING_DEPTH;
                                if (tx_count < RING_DEPTH)
                                    tx_count++;
                                r.tx_request = 1'b1;
                            end
                        end
                        REG_IER:
                        begin
                            if (dlab)
                                shadow_dlm = d;
                            else
                                shadow_ier = d;
                        end
                        REG_IIR_FCR:
                        begin
                            if (d[FCR_CLEAR_BIT])
                            begin
                                tx_head = 0;
                                tx_tail = 0;
                                tx_count = 0;
                            end
                            shadow_fifo_on = d[FCR_ENABLE_BIT];
                        end
                        REG_LCR: shadow_lcr = d;
                        REG_MCR: shadow_mcr = d;
                        REG_SCR: shadow_scr = d;
                        default: r.status = 1'b1;
                    endcase
                end
            end
            FUNC_DRAIN:
            begin
                if (tx_count > 0)
                begin
                    r.tx_valid = 1'b1;
                    r.tx_byte = tx_shadow[tx_head];
                    tx_head = (tx_head + 1) % RING_DEPTH;
                    tx_count--;
                end
            end
            default:
            begin
                // unused function code: all zero, nothing changes
            end
        endcase
        return r;
    endfunction

    function automatic offset_t reg_offset(input reg_idx_t r);
        return {3'b000, r, 2'($urandom)};
    endfunction

    // Offer one beat, hold it until accepted, then record its reply
    task automatic send_beat(input func_t f, input offset_t o, input byte_t d);
        while (idle_enabled && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        offset     <= o;
        write_data <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        reply_q.push_back(predict_reply(f, o, d));
        @(negedge clk);
    endtask

    task automatic send_random_access();
        int       pick;
        reg_idx_t idx;
        offset_t  o;
        byte_t    d;
        pick = $urandom_range(99);
        idx = reg_idx_t'($urandom_range(7));
        d = byte_t'($urandom);
        if (pick < 3)
            send_beat(FUNC_UNUSED, offset_t'($urandom), d);
        else if (pick < 36)
        begin
            o = ($urandom_range(99) < 5) ? offset_t'($urandom_range(32, 255)) : reg_offset(idx);
            send_beat(FUNC_READ, o, d);
        end
        else if (pick < 82)
        begin
            // favor THR so the ring sees real traffic
            if ($urandom_range(1) == 0)
                idx = REG_RBR_THR;
            // keep DLAB clear most of the time so THR writes reach the ring
            if (idx == REG_LCR && $urandom_range(3) != 0)
                d[DLAB_BIT] = 1'b0;
            // clearing on every FCR write would keep the ring shallow
            if (idx == REG_IIR_FCR && $urandom_range(3) != 0)
                d[FCR_CLEAR_BIT] = 1'b0;
            o = ($urandom_range(99) < 5) ? offset_t'($urandom_range(32, 255)) : reg_offset(idx);
            send_beat(FUNC_WRITE, o, d);
        end
        else
            send_beat(FUNC_DRAIN, offset_t'($urandom), d);
    endtask

    task automatic test_register_map();
        // DLAB on: index 0 and 1 reach the divisor latch
        send_beat(FUNC_WRITE, reg_offset(REG_LCR), 8'hFF);
        send_beat(FUNC_WRITE, 8'h03, 8'hFF);
        send_beat(FUNC_WRITE, 8'h04, 8'h5A);
        send_beat(FUNC_READ, 8'h00, 8'h00);
        send_beat(FUNC_READ, 8'h07, 8'hFF);
        send_beat(FUNC_READ, reg_offset(REG_LCR), 8'h00);
        // DLAB off: back to THR/RBR and IER
        send_beat(FUNC_WRITE, reg_offset(REG_LCR), 8'h00);
        send_beat(FUNC_WRITE, reg_offset(REG_IER), 8'hFF);
        send_beat(FUNC_READ, reg_offset(REG_IER), 8'h00);
        send_beat(FUNC_WRITE, reg_offset(REG_MCR), 8'hFF);
        send_beat(FUNC_WRITE, 8'h1F, 8'hFF);
        send_beat(FUNC_READ, 8'h1C, 8'h00);
        send_beat(FUNC_READ, reg_offset(REG_RBR_THR), 8'h00);
        send_beat(FUNC_READ, reg_offset(REG_IIR_FCR), 8'h00);
        send_beat(FUNC_READ, reg_offset(REG_MSR), 8'h00);
    endtask

    task automatic test_error_responses();
        send_beat(FUNC_READ, 8'h20, 8'h00);
        send_beat(FUNC_WRITE, 8'hFF, 8'hFF);
        send_beat(FUNC_WRITE, reg_offset(REG_LSR), 8'hFF);
        send_beat(FUNC_WRITE, reg_offset(REG_MSR), 8'hFF);
        send_beat(FUNC_UNUSED, 8'hFF, 8'hFF);
    endtask

    task automatic test_transmit_ring();
        // FIFO off: capacity one, second push drops the first byte
        send_beat(FUNC_WRITE, reg_offset(REG_RBR_THR), 8'h00);
        send_beat(FUNC_WRITE, reg_offset(REG_RBR_THR), 8'hFF);
        send_beat(FUNC_READ, reg_offset(REG_LSR), 8'h00);
        send_beat(FUNC_DRAIN, 8'h00, 8'h00);
        send_beat(FUNC_DRAIN, 8'hFF, 8'hFF);
        // FIFO on, then off while holding two bytes
        send_beat(FUNC_WRITE, reg_offset(REG_IIR_FCR), 8'h01);
        send_beat(FUNC_WRITE, reg_offset(REG_RBR_THR), 8'h11);
        send_beat(FUNC_WRITE, reg_offset(REG_RBR_THR), 8'h22);
        send_beat(FUNC_WRITE, reg_offset(REG_IIR_FCR), 8'h00);
        send_beat(FUNC_WRITE, reg_offset(REG_RBR_THR), 8'h44);
        send_beat(FUNC_DRAIN, 8'h00, 8'h00);
        // clear and enable in one write
        send_beat(FUNC_WRITE, reg_offset(REG_IIR_FCR), 8'h05);
    endtask

    task automatic test_random_traffic(input int beats);
        repeat (beats)
            send_random_access();
    endtask

    // Fill the ring in bursts, then drain it, across FIFO modes
    task automatic test_ring_bursts(input int rounds);
        byte_t ctl;
        int    pushes;
        int    drains;
        repeat (rounds)
        begin
            ctl = byte_t'($urandom);
            ctl[DLAB_BIT] = 1'b0;
            send_beat(FUNC_WRITE, reg_offset(REG_LCR), ctl);
            ctl = byte_t'($urandom);
            ctl[FCR_ENABLE_BIT] = ($urandom_range(4) != 0);
            ctl[FCR_CLEAR_BIT] = ($urandom_range(3) == 0);
            send_beat(FUNC_WRITE, reg_offset(REG_IIR_FCR), ctl);
            pushes = $urandom_range(1, 2 * RING_DEPTH);
            repeat (pushes)
                send_beat(FUNC_WRITE, reg_offset(REG_RBR_THR), byte_t'($urandom));
            // turn the FIFO off while it may still hold several bytes
            if ($urandom_range(3) == 0)
            begin
                ctl = byte_t'($urandom);
                ctl[FCR_ENABLE_BIT] = 1'b0;
                ctl[FCR_CLEAR_BIT] = 1'b0;
                send_beat(FUNC_WRITE, reg_offset(REG_IIR_FCR), ctl);
                send_beat(FUNC_WRITE, reg_offset(REG_RBR_THR), byte_t'($urandom));
            end
            send_beat(FUNC_READ, reg_offset(REG_LSR), byte_t'($urandom));
            drains = $urandom_range(0, RING_DEPTH + 2);
            repeat (drains)
            begin
                if ($urandom_range(9) == 0)
                    send_random_access();
                else
                    send_beat(FUNC_DRAIN, offset_t'($urandom), byte_t'($urandom));
            end
            send_beat(FUNC_READ, reg_offset(REG_IIR_FCR), byte_t'($urandom));
        end
    endtask

    task automatic test_back_to_back(input int beats);
        idle_enabled = 1'b0;
        test_random_traffic(beats);
        idle_enabled = 1'b1;
    endtask

    // Receiver holds off while beats keep coming, so the input backs up
    task automatic test_output_backpressure(input int beats);
        hold_request = 1'b1;
        test_random_traffic(beats);
    endtask

    // Receiver: random stalls, or a long counted hold when requested
    initial
    begin : drive_out_stall
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                for (hold_count = 1; hold_count < HOLD_CYCLES; hold_count++)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            else
                out_stall <= idle_enabled && ($urandom_range(99) < 9);
        end
    end

    // Compare each result beat with the oldest expected reply
    always @(posedge clk)
    begin : check_reply
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (reply_q.size() == 0)
                report_mismatch("result beat with no reply expected");
            else
            begin
                want = reply_q.pop_front();
                if (read_data !== want.read_data)
                    report_mismatch($sformatf("read_data got %02h want %02h",
                                              read_data, want.read_data));
                if (status !== want.status)
                    report_mismatch($sformatf("status got %b want %b", status, want.status));
                if (tx_request !== want.tx_request)
                    report_mismatch($sformatf("tx_request got %b want %b",
                                              tx_request, want.tx_request));
                if (tx_valid !== want.tx_valid)
                    report_mismatch($sformatf("tx_valid got %b want %b",
                                              tx_valid, want.tx_valid));
                if (tx_byte !== want.tx_byte)
                    report_mismatch($sformatf("tx_byte got %02h want %02h",
                                              tx_byte, want.tx_byte));
            end
        end
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : run_tests
        int wait_cycles;
        in_valid   = 1'b0;
        func       = FUNC_READ;
        offset     = '0;
        write_data = '0;
        rst_n      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_register_map();
        test_error_responses();
        test_transmit_ring();
        test_random_traffic(700);
        test_ring_bursts(30);
        test_back_to_back(250);
        test_output_backpressure(50);
        test_random_traffic(100);

        // drain outstanding replies, then watch for stray beats
        in_valid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 2000 && reply_q.size() != 0; wait_cycles++)
            @(posedge clk);
        if (reply_q.size() != 0)
            report_mismatch($sformatf("%0d expected replies never arrived", reply_q.size()));
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
